>>> src/stop_and_wait_frame_receiver_core_defines.svh
// assertion helpers for the receiver core
`ifndef STOP_AND_WAIT_FRAME_RECEIVER_CORE_DEFINES_SVH
`define STOP_AND_WAIT_FRAME_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SWFR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swfr: same-cycle check failed");

// next-cycle implication, checked out of reset
`define SWFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swfr: next-cycle check failed");

`endif

>>> src/swfr_pkg.sv
package swfr_pkg;

  localparam logic [15:0] CRC_GEN  = 16'h8005;
  localparam logic [16:0] CRC_SAT  = 17'h10000;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2b;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  localparam logic [1:0] WORD_NONE = 2'd0;
  localparam logic [1:0] WORD_CRC  = 2'd1;
  localparam logic [1:0] WORD_SEQ  = 2'd3;

  typedef struct packed {
    logic past_three;
    logic seq_bad;
    logic seq_stop;
    logic seq_digit;
    logic crc_bad;
    logic crc_stop;
  } swfr_flags_t;

  // frame_accepted sits in the lowest bit
  typedef struct packed {
    logic [15:0] ack_number;
    logic        ack_valid;
    logic        crc_matched;
    logic        seq_matched;
    logic        frame_accepted;
  } swfr_result_t;

  localparam int RESULT_BITS = $bits(swfr_result_t);
  localparam int OUT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;

  // eight bit steps, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] rem, input logic [7:0] b);
    logic [15:0] r;
    logic        top;
    r = rem;
    for (int i = 7; i >= 0; i--) begin
      top = r[15];
      r = {r[14:0], 1'b0};
      if (top) r = r ^ CRC_GEN;
      if (b[i]) r = r ^ CRC_GEN;
    end
    return r;
  endfunction

endpackage

>>> src/swfr_frame.sv
module swfr_frame
  import swfr_pkg::*;
#(
  parameter int SEQ_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output swfr_result_t result
);

  localparam int SVW = SEQ_WIDTH + 5;
  localparam logic [SEQ_WIDTH:0] SEQ_SAT = {1'b1, {SEQ_WIDTH{1'b0}}};

  logic [SEQ_WIDTH-1:0] expected_seq;
  logic                 accepted_any;
  logic [15:0]          crc_remainder;
  logic [1:0]           word_index;
  logic                 inside_word;
  logic                 space_owed;
  logic [16:0]          crc_field_value;
  logic [SEQ_WIDTH:0]   seq_field_value;
  swfr_flags_t          field_flags;
  logic                 line_ended;
  logic                 first_byte;

  logic [15:0]          crc_remainder_next;
  logic [1:0]           word_index_next;
  logic                 inside_word_next;
  logic                 space_owed_next;
  logic [16:0]          crc_field_value_next;
  logic [SEQ_WIDTH:0]   seq_field_value_next;
  swfr_flags_t          field_flags_next;
  logic                 line_ended_next;

  logic                 is_digit;
  logic                 is_sign;
  logic                 word_start;
  logic [3:0]           digit;
  logic [20:0]          crc_prod;
  logic [SVW-1:0]       seq_prod;
  logic                 crc_ok;
  logic                 seq_ok;
  logic                 accept;
  logic [SEQ_WIDTH-1:0] expected_seq_next;
  logic [SEQ_WIDTH-1:0] ack_seq;

  assign is_digit = (data_byte >= CHR_ZERO) && (data_byte <= CHR_NINE);
  assign is_sign  = (data_byte == CHR_PLUS) || (data_byte == CHR_MINUS);
  assign digit    = 4'(data_byte - CHR_ZERO);
  assign crc_prod = (21'(crc_field_value) << 3) + (21'(crc_field_value) << 1) + 21'(digit);
  assign seq_prod = (SVW'(seq_field_value) << 3) + (SVW'(seq_field_value) << 1) + SVW'(digit);

  always_comb begin
    crc_remainder_next   = crc_remainder;
    word_index_next      = word_index;
    inside_word_next     = inside_word;
    space_owed_next      = space_owed;
    crc_field_value_next = crc_field_value;
    seq_field_value_next = seq_field_value;
    field_flags_next     = field_flags;
    line_ended_next      = line_ended;
    word_start           = 1'b0;
    if (!line_ended) begin
      if (data_byte == CHR_NUL ||
          (!first_byte && (data_byte == CHR_CR || data_byte == CHR_LF))) begin
        line_ended_next = 1'b1;
      end else if (data_byte == CHR_SPACE) begin
        if (inside_word && word_index >= 2'd2) space_owed_next = 1'b1;
        inside_word_next = 1'b0;
      end else begin
        word_start       = !inside_word;
        inside_word_next = 1'b1;
        if (word_start) begin
          if (word_index == WORD_SEQ) field_flags_next.past_three = 1'b1;
          else word_index_next = word_index + 2'd1;
          if (space_owed) begin
            crc_remainder_next = crc_feed(crc_remainder, CHR_SPACE);
            space_owed_next    = 1'b0;
          end
        end
        if (word_index_next == WORD_CRC) begin
          if (!field_flags.crc_stop) begin
            if (is_digit) begin
              crc_field_value_next = (crc_prod > 21'(CRC_SAT)) ? CRC_SAT : crc_prod[16:0];
            end else begin
              if (word_start && is_sign) field_flags_next.crc_bad = 1'b1;
              field_flags_next.crc_stop = 1'b1;
            end
          end
        end else begin
          crc_remainder_next = crc_feed(crc_remainder_next, data_byte);
          if (word_index_next == WORD_SEQ && !field_flags_next.past_three &&
              !field_flags.seq_stop) begin
            if (is_digit) begin
              seq_field_value_next = (seq_prod > SVW'(SEQ_SAT)) ? SEQ_SAT
                                                                : seq_prod[SEQ_WIDTH:0];
              field_flags_next.seq_digit = 1'b1;
            end else begin
              if (word_start && is_sign) field_flags_next.seq_bad = 1'b1;
              field_flags_next.seq_stop = 1'b1;
            end
          end
        end
      end
    end
  end

  // decision on the state as it stands after this byte
  assign crc_ok = !field_flags_next.crc_bad &&
                  (crc_field_value_next == {1'b0, crc_remainder_next});
  assign seq_ok = (word_index_next == WORD_SEQ) && field_flags_next.seq_digit &&
                  !field_flags_next.seq_bad &&
                  (seq_field_value_next == {1'b0, expected_seq});
  assign accept = crc_ok && seq_ok;
  assign expected_seq_next = accept ? expected_seq + 1'b1 : expected_seq;
  assign ack_seq = expected_seq_next - 1'b1;

  always_comb begin
    result.frame_accepted = accept;
    result.seq_matched    = seq_ok;
    result.crc_matched    = crc_ok;
    result.ack_valid      = accepted_any || accept;
    result.ack_number     = (accepted_any || accept) ? 16'(ack_seq) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq    <= '0;
      accepted_any    <= 1'b0;
      crc_remainder   <= '0;
      word_index      <= WORD_NONE;
      inside_word     <= 1'b0;
      space_owed      <= 1'b0;
      crc_field_value <= '0;
      seq_field_value <= '0;
      field_flags     <= '0;
      line_ended      <= 1'b0;
      first_byte      <= 1'b1;
    end else if (step) begin
      if (last_byte) begin
        expected_seq    <= expected_seq_next;
        accepted_any    <= accepted_any || accept;
        crc_remainder   <= '0;
        word_index      <= WORD_NONE;
        inside_word     <= 1'b0;
        space_owed      <= 1'b0;
        crc_field_value <= '0;
        seq_field_value <= '0;
        field_flags     <= '0;
        line_ended      <= 1'b0;
        first_byte      <= 1'b1;
      end else begin
        crc_remainder   <= crc_remainder_next;
        word_index      <= word_index_next;
        inside_word     <= inside_word_next;
        space_owed      <= space_owed_next;
        crc_field_value <= crc_field_value_next;
        seq_field_value <= seq_field_value_next;
        field_flags     <= field_flags_next;
        line_ended      <= line_ended_next;
        first_byte      <= 1'b0;
      end
    end
  end

endmodule

>>> src/stop_and_wait_frame_receiver_core.sv
// channel   | dir | tdata                                  | tlast     | tuser
// s_axis    | in  | data_byte[7:0]                         | last_byte | -
// m_axis    | out | frame_accepted, seq_matched,           | -         | -
//           |     | crc_matched, ack_valid, ack_number     |           |
//
// one byte a cycle sustained, one request in per cycle, unless a final byte
// waits on a full result slot; a frame's verdict goes into the result register
// the per-byte crc (eight bit steps) and decimal update are combinational,
// between the input register and the result register
// rst is synchronous and clears the expected number and all frame state
// only a final byte waits on a full result register; other bytes never stall
module stop_and_wait_frame_receiver_core
  import swfr_pkg::*;
#(
  parameter int SEQ_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // data_byte[7:0]
  input  logic                   s_axis_tlast,  // last_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // frame_accepted[0], seq_matched[1], crc_matched[2], ack_valid[3],
  // ack_number[19:4], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  `include "stop_and_wait_frame_receiver_core_defines.svh"

  // input register
  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;

  // result register
  logic         out_valid;
  swfr_result_t out_result;

  logic         out_free;
  logic         advance;
  swfr_result_t frame_result;

  // a held request moves on unless it is a final byte facing a full result slot
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  swfr_frame #(
    .SEQ_WIDTH (SEQ_WIDTH)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .result    (frame_result)
  );

  // verdict loads on the final byte, clears once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_result <= frame_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_result);

  // ordinary bytes always flow on
  `SWFR_ASSERT_NOW(a_byte_flows, clk, rst, in_valid && !in_last, advance)
  // a final byte always yields a verdict
  `SWFR_ASSERT_NEXT(a_verdict_loads, clk, rst, advance && in_last, m_axis_tvalid)
  // acceptance needs both checks and leaves a valid ack
  `SWFR_ASSERT_NOW(a_accept_implies, clk, rst, m_axis_tvalid && out_result.frame_accepted,
    out_result.seq_matched && out_result.crc_matched && out_result.ack_valid)
  // without any acceptance the ack number stays zero
  `SWFR_ASSERT_NOW(a_ack_zero, clk, rst, m_axis_tvalid && !out_result.ack_valid,
    out_result.ack_number == 16'd0)

endmodule

>>> sim/tb_stop_and_wait_frame_receiver_core.sv
module tb_stop_and_wait_frame_receiver_core;
  timeunit 1ns;
  timeprecision 1ps;
  import swfr_pkg::*;

  localparam int SEQ_W        = 16;
  localparam int IDLE_PCT     = 18;
  localparam int RANDOM_BYTES = 1250;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'h00;  // data_byte[7:0]
  logic                   s_axis_tlast = 1'b0;   // last_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // frame_accepted[0], seq_matched[1], crc_matched[2], ack_valid[3],
  // ack_number[19:4], zero fill above
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  stop_and_wait_frame_receiver_core #(
    .SEQ_WIDTH(SEQ_W)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // receiver state as the testbench sees it
  // ---------------------------------------------------------------------
  logic [SEQ_W-1:0] exp_seq;       // next sequence number to be accepted
  bit               acc_any;       // something accepted since reset
  logic [15:0]      crc_rem;       // running crc over words two onward
  int unsigned      word_no;       // current word, stops counting at three
  bit               in_word;
  bit               gap_owed;      // single space still to go into the crc
  bit               line_done;     // terminator seen, rest of frame ignored
  bit               at_first;      // next byte is byte zero of the frame
  longint unsigned  crc_val;       // decimal value of word one
  longint unsigned  seq_val;       // decimal value of word three
  swfr_flags_t      frame_flags;

  swfr_result_t     verdict_q[$];  // verdicts waiting on the output side
  logic [7:0]       frame_buf[$];  // frame under construction
  int               err_count;
  int               bytes_sent;
  int               cycles;
  bit               tx_calm;       // sender never pauses while set
  bit               rx_calm;       // sink never stalls while set

  function automatic logic [15:0] crc_byte(logic [15:0] r, logic [7:0] b);
    // shifting in the data bit and the carried-out bit cancel each other
    for (int k = 7; k >= 0; k--)
      r = {r[14:0], 1'b0} ^ ((r[15] ^ b[k]) ? CRC_GEN : 16'h0000);
    return r;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CHR_ZERO && b <= CHR_NINE;
  endfunction

  function automatic longint unsigned push_digit(longint unsigned v, logic [7:0] b,
                                                 longint unsigned cap);
    v = v * 10 + longint'(b - CHR_ZERO);
    return (v > cap) ? cap : v;
  endfunction

  function automatic void clear_frame();
    crc_rem     = 16'h0000;
    word_no     = 0;
    in_word     = 1'b0;
    gap_owed    = 1'b0;
    line_done   = 1'b0;
    at_first    = 1'b1;
    crc_val     = 0;
    seq_val     = 0;
    frame_flags = '0;
  endfunction

  // one accepted request; a final byte queues the verdict for its frame
  function automatic void receiver_take_byte(logic [7:0] b, bit last);
    bit           starting;
    bit           crc_hit;
    bit           seq_hit;
    swfr_result_t v;
    if (!line_done) begin
      if (b == CHR_NUL || (!at_first && (b == CHR_CR || b == CHR_LF))) begin
        line_done = 1'b1;
      end else if (b == CHR_SPACE) begin
        // runs of spaces count once, and only between crc-covered words
        if (in_word && word_no >= 2) gap_owed = 1'b1;
        in_word = 1'b0;
      end else begin
        starting = !in_word;
        if (starting) begin
          in_word = 1'b1;
          if (word_no >= 3) frame_flags.past_three = 1'b1;
          else word_no++;
          if (gap_owed) begin
            crc_rem  = crc_byte(crc_rem, CHR_SPACE);
            gap_owed = 1'b0;
          end
        end
        if (word_no == 1) begin
          if (!frame_flags.crc_stop) begin
            if (is_digit(b)) begin
              crc_val = push_digit(crc_val, b, longint'(CRC_SAT));
            end else begin
              if (starting && (b == CHR_PLUS || b == CHR_MINUS)) frame_flags.crc_bad = 1'b1;
              frame_flags.crc_stop = 1'b1;
            end
          end
        end else begin
          crc_rem = crc_byte(crc_rem, b);
          if (word_no == 3 && !frame_flags.past_three && !frame_flags.seq_stop) begin
            if (is_digit(b)) begin
              seq_val = push_digit(seq_val, b, longint'(1) << SEQ_W);
              frame_flags.seq_digit = 1'b1;
            end else begin
              if (starting && (b == CHR_PLUS || b == CHR_MINUS)) frame_flags.seq_bad = 1'b1;
              frame_flags.seq_stop = 1'b1;
            end
          end
        end
      end
    end
    at_first = 1'b0;
    if (last) begin
      crc_hit = !frame_flags.crc_bad && crc_val == longint'(crc_rem);
      seq_hit = word_no == 3 && frame_flags.seq_digit && !frame_flags.seq_bad &&
                seq_val == longint'(exp_seq);
      if (crc_hit && seq_hit) begin
        acc_any = 1'b1;
        exp_seq = exp_seq + 1'b1;
      end
      v.frame_accepted = crc_hit && seq_hit;
      v.seq_matched    = seq_hit;
      v.crc_matched    = crc_hit;
      v.ack_valid      = acc_any;
      v.ack_number     = acc_any ? 16'(exp_seq - 1'b1) : 16'h0000;
      verdict_q.push_back(v);
      clear_frame();
    end
  endfunction

  // ---------------------------------------------------------------------
  // frame text helpers
  // ---------------------------------------------------------------------
  function automatic logic [15:0] crc_of(string s);
    logic [15:0] r;
    r = 16'h0000;
    for (int i = 0; i < s.len(); i++) r = crc_byte(r, s[i]);
    return r;
  endfunction

  function automatic string crc_text(string body);
    return $sformatf("%0d", crc_of(body));
  endfunction

  function automatic string next_seq();
    return $sformatf("%0d", exp_seq);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endfunction

  function automatic void put_spaces(int n);
    repeat (n) frame_buf.push_back(CHR_SPACE);
  endfunction

  // crc text, one space, then the covered words
  function automatic void put_signed(string body);
    put_text({crc_text(body), " ", body});
  endfunction

  // any byte that keeps a word going: mostly printable, otherwise any non-separator byte
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(99) < 70) ? 8'($urandom_range(8'h7e, 8'h21)) : 8'($urandom);
    end while (c == CHR_NUL || c == CHR_LF || c == CHR_CR || c == CHR_SPACE);
    return c;
  endfunction

  function automatic string rand_word(int max_len);
    string w;
    w = "";
    repeat ($urandom_range(max_len, 1)) w = $sformatf("%s%c", w, word_char());
    return w;
  endfunction

  // a frame in the shape a sender would produce, with random content and
  // now and then a stale or wrong sequence, a corrupted crc, odd spacing
  // or a terminator followed by junk
  function automatic void build_clean_frame();
    string            body;
    string            crc_s;
    logic [SEQ_W-1:0] seq;
    logic [15:0]      crc;
    int               pick;
    bit               messy;
    pick = $urandom_range(99);
    seq = (pick < 75) ? exp_seq : (pick < 85) ? exp_seq - 1'b1 : SEQ_W'($urandom);
    body = $sformatf("%s %s%0d", rand_word(6), ($urandom_range(9) == 0) ? "00" : "", seq);
    if ($urandom_range(9) == 0) body = {body, "x"};
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(3, 1)) body = {body, " ", rand_word(5)};
    crc = crc_of(body);
    if ($urandom_range(99) < 15) crc ^= 16'($urandom_range(16'hffff, 1));
    crc_s = $sformatf("%0d", crc);
    if ($urandom_range(9) == 0) crc_s = {crc_s, "k"};
    messy = ($urandom_range(3) == 0);
    put_spaces(messy ? $urandom_range(2) : 0);
    put_text(crc_s);
    put_spaces(messy ? $urandom_range(3, 1) : 1);
    for (int i = 0; i < body.len(); i++) begin
      if (body[i] == CHR_SPACE && messy) put_spaces($urandom_range(3, 1));
      else frame_buf.push_back(body[i]);
    end
    if (messy) put_spaces($urandom_range(2));
    pick = $urandom_range(9);
    if (pick == 0) begin
      frame_buf.push_back($urandom_range(1) ? CHR_CR : CHR_LF);
      repeat ($urandom_range(4)) frame_buf.push_back(8'($urandom));
    end else if (pick == 1) begin
      frame_buf.push_back(CHR_NUL);
      repeat ($urandom_range(4)) frame_buf.push_back(8'($urandom));
    end
  endfunction

  // ---------------------------------------------------------------------
  // stimulus: one request per byte, driven on the falling edge
  // ---------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, bit last);
    if (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      // idle gap with garbage on the bus
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tlast  <= 1'($urandom);
      do @(negedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    receiver_take_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    if (frame_buf.size() == 0) frame_buf.push_back(8'($urandom));
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frame_buf.delete();
  endtask

  // ---------------------------------------------------------------------
  // result side: random stalls, check on every handshake
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    m_axis_tready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t ns: mismatch in %s, got %0d, want %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    swfr_result_t seen;
    swfr_result_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      seen = m_axis_tdata[RESULT_BITS-1:0];
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with none outstanding", seen, 0);
      end else begin
        want = verdict_q.pop_front();
        if (seen.frame_accepted !== want.frame_accepted)
          report_mismatch("frame_accepted", seen.frame_accepted, want.frame_accepted);
        if (seen.seq_matched !== want.seq_matched)
          report_mismatch("seq_matched", seen.seq_matched, want.seq_matched);
        if (seen.crc_matched !== want.crc_matched)
          report_mismatch("crc_matched", seen.crc_matched, want.crc_matched);
        if (seen.ack_valid !== want.ack_valid)
          report_mismatch("ack_valid", seen.ack_valid, want.ack_valid);
        if (seen.ack_number !== want.ack_number)
          report_mismatch("ack_number", seen.ack_number, want.ack_number);
        if ((m_axis_tdata >> RESULT_BITS) !== '0)
          report_mismatch("tdata fill", m_axis_tdata >> RESULT_BITS, 0);
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // well-formed frames that should go through, plus a duplicate
  task automatic test_good_frames();
    string body;
    put_signed({"hello ", next_seq()});
    send_frame();
    // retransmission of the frame just accepted
    put_signed({"hello ", $sformatf("%0d", exp_seq - 1'b1)});
    send_frame();
    // leading, repeated and trailing spaces collapse
    body = {"data ", next_seq()};
    put_text({"  ", crc_text(body), "   data   ", next_seq(), "  "});
    send_frame();
    // words past the third are still covered by the crc
    put_signed({"x ", next_seq(), " tail more words"});
    send_frame();
    put_signed({"p 000", next_seq()});
    send_frame();
    // digits end the sequence number at the first non-digit
    put_signed({"q ", next_seq(), "ok"});
    send_frame();
    body = {"r ", next_seq()};
    put_text({crc_text(body), "z ", body});
    send_frame();
  endtask

  // signs, overflow and wrong crc text
  task automatic test_field_errors();
    string body;
    body = {"m ", next_seq()};
    put_text({"+", crc_text(body), " ", body});
    send_frame();
    put_text({"-", crc_text(body), " ", body});
    send_frame();
    put_signed({"m -", next_seq()});
    send_frame();
    put_signed({"m +", next_seq()});
    send_frame();
    put_text({crc_text(body), "1 ", body});
    send_frame();
    put_text({"99999999 ", body});
    send_frame();
    put_text({"65536 ", body});
    send_frame();
    put_signed("m 65536");
    send_frame();
    put_signed("m 99999999999");
    send_frame();
    put_signed({"m ", next_seq()});
    send_frame();
  endtask

  // frames with too few words, empty crc text and single-byte frames
  task automatic test_short_and_missing();
    put_text("0");
    send_frame();
    put_text("x");
    send_frame();
    put_text("+");
    send_frame();
    put_signed("w");
    send_frame();
    put_signed("w x6");
    send_frame();
    put_text("   ");
    send_frame();
    frame_buf.push_back(CHR_NUL);
    send_frame();
    frame_buf.push_back(8'hff);
    send_frame();
    frame_buf = '{8'hff, 8'h80, CHR_SPACE, 8'h7f, CHR_SPACE, 8'hff};
    send_frame();
  endtask

  // cr, lf and nul cutting a frame short
  task automatic test_terminators();
    // line break as byte zero is part of word one
    frame_buf.push_back(CHR_LF);
    put_text(" 0 w 1");
    send_frame();
    frame_buf.push_back(CHR_CR);
    send_frame();
    put_signed({"t ", next_seq()});
    frame_buf.push_back(CHR_CR);
    frame_buf.push_back(CHR_LF);
    put_text(" junk 99");
    send_frame();
    put_signed({"u ", next_seq()});
    frame_buf.push_back(CHR_NUL);
    put_text("77");
    send_frame();
    frame_buf.push_back(CHR_NUL);
    put_signed({"v ", next_seq()});
    send_frame();
    put_text("12 w ");
    frame_buf.push_back(CHR_LF);
    put_text(next_seq());
    send_frame();
  endtask

  // a long stretch with neither side pausing
  task automatic test_back_to_back();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (20) begin
      build_clean_frame();
      send_frame();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // mostly well-formed frames, the rest noise and truncated frames
  task automatic test_random_frames();
    int target;
    int pick;
    int keep;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        build_clean_frame();
      end else if (pick < 90) begin
        repeat ($urandom_range(12, 1)) frame_buf.push_back(8'($urandom));
      end else begin
        build_clean_frame();
        keep = $urandom_range(frame_buf.size(), 1);
        while (frame_buf.size() > keep) void'(frame_buf.pop_back());
      end
      send_frame();
    end
  endtask

  initial begin
    exp_seq    = '0;
    acc_any    = 1'b0;
    err_count  = 0;
    bytes_sent = 0;
    cycles     = 0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    clear_frame();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_good_frames();
    test_field_errors();
    test_short_and_missing();
    test_terminators();
    test_back_to_back();
    test_random_frames();

    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    // room for a stray verdict to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
